// ----- hw/rtl/dkts_pkg.sv -----
// ----------------------------------------------------------------------------
// dkts_pkg: shared types, keyword tables and byte classes
// Holds the queue item type, the definition keyword table and the byte
// classification helpers used by the scanner front end.
// ----------------------------------------------------------------------------
package dkts_pkg;

    localparam int KW_COUNT     = 8;
    localparam int KW_MAX_LEN   = 11;
    localparam int KIND_W       = 3;
    localparam int NUM_KINDS    = 6;
    localparam int CHAR_W       = 8;
    localparam int POS_W        = 4;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CH_LINE_END = 8'd10;
    localparam logic [CHAR_W-1:0] CH_D        = 8'h64;
    localparam logic [POS_W-1:0]  POS_MAX     = 4'd15;

    // tag kind codes
    localparam logic [KIND_W-1:0] KIND_MACRO    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FUNCTION = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MODULE   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RECORD   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PROTOCOL = 3'd4;
    localparam logic [KIND_W-1:0] KIND_IMPL     = 3'd5;

    // keyword text, right aligned: first byte is the most significant used byte
    localparam logic [KW_MAX_LEN*CHAR_W-1:0] KW_TEXT [KW_COUNT] = '{
        88'("def"), 88'("defp"), 88'("defmacro"), 88'("defmacrop"),
        88'("defrecord"), 88'("defmodule"), 88'("defprotocol"), 88'("defimpl")
    };
    localparam logic [POS_W-1:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd4, 4'd8, 4'd9, 4'd9, 4'd9, 4'd11, 4'd7
    };
    localparam logic [KIND_W-1:0] KW_KIND [KW_COUNT] = '{
        KIND_FUNCTION, KIND_FUNCTION, KIND_MACRO, KIND_MACRO,
        KIND_RECORD, KIND_MODULE, KIND_PROTOCOL, KIND_IMPL
    };

    // one result item as it travels through the queue
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] tag_char;
        logic              name_end;
    } dkts_item_t;

    typedef struct packed {
        logic       valid;
        dkts_item_t item;
    } dkts_push_t;

    // byte of keyword k at position pos; only meaningful when pos < length
    function automatic logic [CHAR_W-1:0] kw_char(input int k, input logic [POS_W-1:0] pos);
        logic [POS_W-1:0]             sh;
        logic [KW_MAX_LEN*CHAR_W-1:0] txt;
        sh  = KW_LEN[k] - pos - 4'd1;
        txt = KW_TEXT[k] >> {sh, 3'b000};
        return txt[CHAR_W-1:0];
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
    endfunction

    function automatic logic is_ident(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
               (c >= 8'h61 && c <= 8'h7a) || c == 8'h5f || c == 8'h3f || c == 8'h21;
    endfunction

endpackage

// ----- hw/rtl/dkts_front.sv -----
// ----------------------------------------------------------------------------
// dkts_front: line scanner and keyword classifier
// Takes one byte per cycle on byte_accept, tracks the line phase, matches
// the definition keyword, pushes tag name bytes and end markers to the queue.
// ----------------------------------------------------------------------------
module dkts_front
    import dkts_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  byte_accept,
    input  logic [CHAR_W-1:0]     ch,
    input  logic [NUM_KINDS-1:0]  kind_enable,
    output dkts_push_t            push
);

    localparam logic [1:0] PH_LINE_START = 2'd0;
    localparam logic [1:0] PH_KEYWORD    = 2'd1;
    localparam logic [1:0] PH_NAME       = 2'd2;
    localparam logic [1:0] PH_IGNORE     = 2'd3;

    logic [1:0]          phase_reg, phase_next;
    logic [KW_COUNT-1:0] cand_reg, cand_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic                started_reg, started_next;

    logic                emit;
    logic                emit_end;
    logic                found;
    logic [KIND_W-1:0]   found_kind;

    // keyword match at the end of the keyword identifier, lowest index wins
    always_comb begin
        found      = 1'b0;
        found_kind = KIND_MACRO;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (cand_reg[k] && KW_LEN[k] == pos_reg) begin
                found      = 1'b1;
                found_kind = KW_KIND[k];
            end
        end
    end

    // next state and result request for the incoming byte
    always_comb begin
        phase_next   = phase_reg;
        cand_next    = cand_reg;
        pos_next     = pos_reg;
        kind_next    = kind_reg;
        started_next = started_reg;
        emit         = 1'b0;
        emit_end     = 1'b0;
        if (ch == CH_LINE_END) begin
            emit         = (phase_reg == PH_NAME) && started_reg;
            emit_end     = 1'b1;
            phase_next   = PH_LINE_START;
            cand_next    = '1;
            pos_next     = '0;
            started_next = 1'b0;
        end else begin
            case (phase_reg)
                PH_LINE_START: begin
                    if (!is_space(ch)) begin
                        if (ch == CH_D) begin
                            phase_next = PH_KEYWORD;
                            cand_next  = '1;
                            pos_next   = 4'd1;
                        end else begin
                            phase_next = PH_IGNORE;
                        end
                    end
                end
                PH_KEYWORD: begin
                    if (is_ident(ch)) begin
                        for (int k = 0; k < KW_COUNT; k++) begin
                            if (pos_reg >= KW_LEN[k] || kw_char(k, pos_reg) != ch) begin
                                cand_next[k] = 1'b0;
                            end
                        end
                        if (pos_reg != POS_MAX) begin
                            pos_next = pos_reg + 4'd1;
                        end
                    end else begin
                        phase_next = PH_IGNORE;
                        if (found) begin
                            kind_next = found_kind;
                            if (is_space(ch)) begin
                                phase_next   = PH_NAME;
                                started_next = 1'b0;
                            end
                        end
                    end
                end
                PH_NAME: begin
                    if (is_ident(ch)) begin
                        started_next = 1'b1;
                        emit         = 1'b1;
                    end else if (!(!started_reg && is_space(ch))) begin
                        emit         = started_reg;
                        emit_end     = 1'b1;
                        started_next = 1'b0;
                        phase_next   = PH_IGNORE;
                    end
                end
                default: begin
                    phase_next = PH_IGNORE;
                end
            endcase
        end
    end

    // result item, gated by the kind enable bits
    always_comb begin
        push.valid         = byte_accept && emit && kind_enable[kind_reg];
        push.item.kind     = kind_reg;
        push.item.tag_char = emit_end ? '0 : ch;
        push.item.name_end = emit_end;
    end

    // scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_LINE_START;
            cand_reg    <= '1;
            pos_reg     <= '0;
            kind_reg    <= KIND_MACRO;
            started_reg <= 1'b0;
        end else if (byte_accept) begin
            phase_reg   <= phase_next;
            cand_reg    <= cand_next;
            pos_reg     <= pos_next;
            kind_reg    <= kind_next;
            started_reg <= started_next;
        end
    end

endmodule

// ----- hw/rtl/dkts_queue.sv -----
// ----------------------------------------------------------------------------
// dkts_queue: short result queue
// Small register queue between the scanner front end and the output stage,
// so that each side can stall on its own.
// ----------------------------------------------------------------------------
module dkts_queue
    import dkts_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  dkts_push_t push,
    output logic       full,
    output logic       not_empty,
    input  logic       pop,
    output dkts_item_t head
);

    dkts_item_t        store_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = store_reg[rd_ptr_reg];
    assign do_push   = push.valid && !full;
    assign do_pop    = pop && not_empty;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (!do_push && do_pop) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // item storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push.item;
        end
    end

endmodule

// ----- hw/rtl/dkts_back.sv -----
// ----------------------------------------------------------------------------
// dkts_back: output register stage
// Pulls result items from the queue into the output register and holds
// them until the receiver takes them.
// ----------------------------------------------------------------------------
module dkts_back
    import dkts_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_not_empty,
    input  dkts_item_t        q_head,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [KIND_W-1:0] m_kind,
    output logic [CHAR_W-1:0] m_tag_char,
    output logic              m_name_end
);

    logic       valid_reg;
    dkts_item_t item_reg;

    assign q_pop      = q_not_empty && (!valid_reg || m_ready);
    assign m_valid    = valid_reg;
    assign m_kind     = item_reg.kind;
    assign m_tag_char = item_reg.tag_char;
    assign m_name_end = item_reg.name_end;

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (!valid_reg || m_ready) begin
            valid_reg <= q_not_empty;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg <= q_head;
        end
    end

endmodule

// ----- hw/rtl/definition_keyword_tag_scanner.sv -----
// ----------------------------------------------------------------------------
// definition_keyword_tag_scanner: tag scanner for definition keywords
// Scans a source text byte stream line by line and streams out the names
// that follow definition keywords, tagged with their kind.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_ch carries one source byte per item; byte 10 ends a
//   line. m_valid/m_ready carries result items: m_kind, m_tag_char and
//   m_name_end (set on the end marker after each name, with m_tag_char 0).
//   cfg_valid/cfg_ready/cfg_data writes the six kind enable bits; the port
//   is always ready and should be written only while the block is idle.
// Timing:
//   one byte is taken every cycle while the result queue has room. A
//   result item is written into the queue at the edge that takes its byte
//   and moves on into the output register, behind any items ahead of it,
//   once that register is empty or m_ready is high; m_valid then rises.
//   Sustained rate is one byte per cycle while the queue has room.
// Reset:
//   aresetn is synchronous, active low. It empties the queue and output
//   register, returns the scanner to line start and enables all kinds.
// Stall:
//   when m_ready stays low, the four-entry queue fills and s_ready drops
//   until the receiver takes items again; nothing is lost.
// ----------------------------------------------------------------------------
module definition_keyword_tag_scanner
    import dkts_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CHAR_W-1:0]     s_ch,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [KIND_W-1:0]     m_kind,
    output logic [CHAR_W-1:0]     m_tag_char,
    output logic                  m_name_end,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [NUM_KINDS-1:0]  cfg_data
);

    logic [NUM_KINDS-1:0]  kind_enable_reg;
    logic                  byte_accept;
    dkts_push_t            push;
    logic                  q_full;
    logic                  q_not_empty;
    logic                  q_pop;
    dkts_item_t            q_head;

    assign s_ready     = !q_full;
    assign byte_accept = s_valid && !q_full;
    assign cfg_ready   = 1'b1;

    // kind enable register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_enable_reg <= '1;
        end else if (cfg_valid) begin
            kind_enable_reg <= cfg_data;
        end
    end

    dkts_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .ch          (s_ch),
        .kind_enable (kind_enable_reg),
        .push        (push)
    );

    dkts_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .head      (q_head)
    );

    dkts_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_tag_char  (m_tag_char),
        .m_name_end  (m_name_end)
    );

endmodule
